[rtl/core/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types, constants and helpers for the rational fraction ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package rfa_pkg;

  // operand width taken from each 32-bit input field (low bits, sign-extended)
  localparam int unsigned OperandWidth = 32;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned MagW         = OperandWidth;
  localparam int unsigned ProdW        = 2 * MagW;
  localparam int unsigned DivW         = 64;
  localparam int unsigned DivCntW      = $clog2(DivW);
  localparam int unsigned DenW         = 62;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD,
    ST_GCD_WAIT,
    ST_DIVN,
    ST_DIVN_WAIT,
    ST_DIVD,
    ST_DIVD_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic               [1:0] opcode;
    logic signed [FieldW-1:0] a_num;
    logic signed [FieldW-1:0] a_den;
    logic signed [FieldW-1:0] b_num;
    logic signed [FieldW-1:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic        [61:0] res_den;
    logic               status;
  } out_t;

  // divider request / response
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
    logic [DivW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } smag_t;

  // sign / magnitude of the low OperandWidth bits
  function automatic smag_t split(input logic [FieldW-1:0] raw);
    smag_t           r;
    logic [MagW-1:0] v;
    v     = raw[MagW-1:0];
    r.neg = v[MagW-1];
    r.mag = v[MagW-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/rational_fraction_alu_unit.sv]
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit
// Exact add / subtract / multiply / divide of two signed fractions, reduced
// by their greatest common divisor.
// ----------------------------------------------------------------------------
// Usage: present a beat on operands_i with start high while busy is low. The
// unit forms the cross products on one 32x32 multiplier (three passes), then
// runs Euclid's remainder loop on a single shared 64-bit restoring divider,
// one quotient bit per cycle, and reuses that divider for the two exact
// divisions by the GCD. The number of Euclid steps depends on the operands;
// it is at most about 90 for 64-bit values, and far fewer for small ones.
// Items with a zero operand denominator skip the multiplier and the divider.
// The result beat appears on result_o for exactly one cycle with
// result_valid_o high; there is no back-pressure, so the receiver must take
// it then. busy drops in the cycle the result is shown, so the next start
// may coincide with it.
// A zero denominator (operand or result) or a reduced denominator wider than
// 62 bits gives status 1 with zero fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_fraction_alu_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire rfa_pkg::in_t operands_i,
  output logic              result_valid_o,
  output rfa_pkg::out_t     result_o
);

  localparam int unsigned W = rfa_pkg::DivW;

  rfa_pkg::state_e state_q, state_d;
  logic            valid_q, valid_d;

  // captured operands, sign / magnitude
  rfa_pkg::op_e              op_q;
  rfa_pkg::smag_t            an_q, ad_q, bn_q, bd_q;
  rfa_pkg::smag_t            an_c, ad_c, bn_c, bd_c;
  logic [rfa_pkg::ProdW-1:0] t0_q, t1_q;
  logic [W-1:0]              num_q, den_q, x_q, y_q;
  logic                      num_s_q, den_s_q, err_q;
  rfa_pkg::out_t             res_q, res_d;

  logic accept;

  // multiplier
  logic [rfa_pkg::MagW-1:0]  mul_a, mul_b;
  logic [rfa_pkg::ProdW-1:0] prod;

  // divider
  rfa_pkg::div_req_t div_req;
  rfa_pkg::div_rsp_t div_rsp;

  // combine step
  logic [W-1:0] m0, m1, comb_num, comb_den;
  logic         s0, s1, comb_s;

  assign accept = start && (state_q == rfa_pkg::ST_IDLE);
  assign busy   = (state_q != rfa_pkg::ST_IDLE);

  assign an_c = rfa_pkg::split(operands_i.a_num);
  assign ad_c = rfa_pkg::split(operands_i.a_den);
  assign bn_c = rfa_pkg::split(operands_i.b_num);
  assign bd_c = rfa_pkg::split(operands_i.b_den);

  rfa_multiplier u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  rfa_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // cross-product terms, signed add of the two numerator terms
  always_comb begin
    m0       = W'(t0_q);
    m1       = W'(t1_q);
    comb_den = W'(prod);
    s0       = an_q.neg ^ ((op_q == rfa_pkg::OP_MUL) ? bn_q.neg : bd_q.neg);
    s1       = ((op_q == rfa_pkg::OP_SUB) ? !bn_q.neg : bn_q.neg) ^ ad_q.neg;
    comb_num = m0;
    comb_s   = s0;
    if (op_q == rfa_pkg::OP_ADD || op_q == rfa_pkg::OP_SUB) begin
      if (s0 == s1) begin
        comb_num = m0 + m1;
      end else if (m0 >= m1) begin
        comb_num = m0 - m1;
      end else begin
        comb_num = m1 - m0;
        comb_s   = s1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (ad_c.mag == '0 || bd_c.mag == '0) ? rfa_pkg::ST_FIN
                                                       : rfa_pkg::ST_MUL0;
        end
      end
      rfa_pkg::ST_MUL0: state_d = rfa_pkg::ST_MUL1;
      rfa_pkg::ST_MUL1: state_d = rfa_pkg::ST_MUL2;
      rfa_pkg::ST_MUL2: state_d = rfa_pkg::ST_COMB;
      rfa_pkg::ST_COMB: begin
        state_d = (comb_den == '0) ? rfa_pkg::ST_FIN : rfa_pkg::ST_GCD;
      end
      rfa_pkg::ST_GCD: begin
        state_d = (y_q == '0) ? rfa_pkg::ST_DIVN : rfa_pkg::ST_GCD_WAIT;
      end
      rfa_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) state_d = rfa_pkg::ST_GCD;
      end
      rfa_pkg::ST_DIVN: state_d = rfa_pkg::ST_DIVN_WAIT;
      rfa_pkg::ST_DIVN_WAIT: begin
        if (div_rsp.done) state_d = rfa_pkg::ST_DIVD;
      end
      rfa_pkg::ST_DIVD: state_d = rfa_pkg::ST_DIVD_WAIT;
      rfa_pkg::ST_DIVD_WAIT: begin
        if (div_rsp.done) state_d = rfa_pkg::ST_FIN;
      end
      rfa_pkg::ST_FIN: state_d = rfa_pkg::ST_IDLE;
      default: state_d = rfa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operand select, divider request
  always_comb begin
    mul_a            = an_q.mag;
    mul_b            = bd_q.mag;
    div_req.start    = 1'b0;
    div_req.dividend = x_q;
    div_req.divisor  = y_q;
    valid_d          = 1'b0;
    case (state_q)
      rfa_pkg::ST_MUL0: begin
        mul_a = an_q.mag;
        mul_b = (op_q == rfa_pkg::OP_MUL) ? bn_q.mag : bd_q.mag;
      end
      rfa_pkg::ST_MUL1: begin
        mul_a = bn_q.mag;
        mul_b = ad_q.mag;
      end
      rfa_pkg::ST_MUL2: begin
        mul_a = ad_q.mag;
        mul_b = (op_q == rfa_pkg::OP_DIV) ? bn_q.mag : bd_q.mag;
      end
      rfa_pkg::ST_GCD: begin
        div_req.start = (y_q != '0);
      end
      rfa_pkg::ST_DIVN: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = x_q;
      end
      rfa_pkg::ST_DIVD: begin
        div_req.start    = 1'b1;
        div_req.dividend = den_q;
        div_req.divisor  = x_q;
      end
      rfa_pkg::ST_FIN: begin
        valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result beat: sign moved to the numerator, zeros on error
  always_comb begin
    logic ok;
    ok = !err_q && (den_q[W-1:rfa_pkg::DenW] == '0);
    res_d.status  = !ok;
    res_d.res_den = ok ? den_q[rfa_pkg::DenW-1:0] : '0;
    res_d.res_num = '0;
    if (ok) begin
      res_d.res_num = (num_s_q ^ den_s_q) ? signed'(~num_q + 1'b1) : signed'(num_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfa_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rfa_pkg::ST_IDLE: begin
        if (accept) begin
          op_q  <= rfa_pkg::op_e'(operands_i.opcode);
          an_q  <= an_c;
          ad_q  <= ad_c;
          bn_q  <= bn_c;
          bd_q  <= bd_c;
          err_q <= (ad_c.mag == '0 || bd_c.mag == '0);
        end
      end
      rfa_pkg::ST_MUL1: t0_q <= prod;
      rfa_pkg::ST_MUL2: t1_q <= prod;
      rfa_pkg::ST_COMB: begin
        num_q   <= comb_num;
        den_q   <= comb_den;
        num_s_q <= comb_s;
        den_s_q <= ad_q.neg ^ ((op_q == rfa_pkg::OP_DIV) ? bn_q.neg : bd_q.neg);
        x_q     <= comb_num;
        y_q     <= comb_den;
        err_q   <= (comb_den == '0);
      end
      rfa_pkg::ST_GCD_WAIT: begin
        if (div_rsp.done) begin
          x_q <= y_q;
          y_q <= div_rsp.rem;
        end
      end
      rfa_pkg::ST_DIVN_WAIT: begin
        if (div_rsp.done) num_q <= div_rsp.quo;
      end
      rfa_pkg::ST_DIVD_WAIT: begin
        if (div_rsp.done) den_q <= div_rsp.quo;
      end
      rfa_pkg::ST_FIN: res_q <= res_d;
      default: begin
      end
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  // the strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // a good result never carries a zero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.status) |-> (result_o.res_den != '0))
    else $error("ok result with zero denominator");

  // the divider is only started while idle
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while running");

  // an accepted beat makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

[rtl/core/rfa_multiplier.sv]
// ----------------------------------------------------------------------------
// rfa_multiplier
// Unsigned magnitude multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rfa_multiplier (
  input  wire logic                      clk_i,
  input  wire logic [rfa_pkg::MagW-1:0]  a_i,
  input  wire logic [rfa_pkg::MagW-1:0]  b_i,
  output logic      [rfa_pkg::ProdW-1:0] p_o
);

  logic [rfa_pkg::ProdW-1:0] p_q, p_d;

  assign p_d = rfa_pkg::ProdW'(a_i) * rfa_pkg::ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[rtl/core/rfa_divider.sv]
// ----------------------------------------------------------------------------
// rfa_divider
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module rfa_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rfa_pkg::div_req_t req_i,
  output rfa_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W = rfa_pkg::DivW;

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [rfa_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]                quo_q, quo_d;
  logic [W-1:0]                rem_q, rem_d;
  logic [W-1:0]                dsr_q, dsr_d;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start && !run_q) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = req_i.dividend;
      rem_d = '0;
      dsr_d = req_i.divisor;
    end else if (run_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rfa_pkg::DivCntW'(W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy = run_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

[verif/rfa_checker.sv]
// ----------------------------------------------------------------------------
// rfa_checker
// Watches the operand and result channels of the rational fraction ALU,
// predicts each reduced fraction and compares it field by field.
// ----------------------------------------------------------------------------
module rfa_checker
  import rfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  in_t  operands_i,
  input  logic result_valid_i,
  input  out_t result_i,
  output int   outstanding_o,
  output int   fail_count_o,
  output int   checked_o,
  output int   err_status_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [63:0] DenMax = (64'd1 << DenW) - 64'd1;

  out_t expected_fracs[$];
  out_t want;

  // low OperandWidth bits as sign and magnitude; the most negative value
  // gives a magnitude of 2^(OperandWidth-1)
  function automatic void sign_mag(input logic [FieldW-1:0] raw, output bit neg,
                                   output bit [63:0] mag);
    bit [63:0] mask;
    bit [63:0] v;
    mask = (64'd1 << OperandWidth) - 64'd1;
    v    = 64'(raw) & mask;
    neg  = v[OperandWidth-1];
    mag  = neg ? ((~v & mask) + 64'd1) : v;
  endfunction

  function automatic out_t reduced_fraction(input in_t beat);
    out_t      res;
    bit        an_s, ad_s, bn_s, bd_s, t_s, p_s, q_s, num_s, den_s;
    bit [63:0] an, ad, bn, bd, p, q, num, den, x, y, r;
    res        = '0;
    res.status = 1'b1;
    sign_mag(beat.a_num, an_s, an);
    sign_mag(beat.a_den, ad_s, ad);
    sign_mag(beat.b_num, bn_s, bn);
    sign_mag(beat.b_den, bd_s, bd);
    if (ad == 0 || bd == 0) return res;
    case (op_e'(beat.opcode))
      OP_ADD, OP_SUB: begin
        t_s = (beat.opcode == OP_SUB) ? ~bn_s : bn_s;
        p_s = an_s ^ bd_s;
        p   = an * bd;
        q_s = t_s ^ ad_s;
        q   = bn * ad;
        if (p_s == q_s) begin
          num_s = p_s;
          num   = p + q;
        end else if (p >= q) begin
          num_s = p_s;
          num   = p - q;
        end else begin
          num_s = q_s;
          num   = q - p;
        end
        den_s = ad_s ^ bd_s;
        den   = ad * bd;
      end
      OP_MUL: begin
        num_s = an_s ^ bn_s;
        num   = an * bn;
        den_s = ad_s ^ bd_s;
        den   = ad * bd;
      end
      default: begin // divide
        num_s = an_s ^ bd_s;
        num   = an * bd;
        den_s = ad_s ^ bn_s;
        den   = ad * bn;
      end
    endcase
    if (den == 0) return res;
    // Euclid; a zero numerator leaves gcd = den, hence 0/1
    x = num;
    y = den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    num = num / x;
    den = den / x;
    if (den > DenMax) return res;
    res.res_num = (num != 0 && (num_s ^ den_s)) ? (64'd0 - num) : num;
    res.res_den = den[DenW-1:0];
    res.status  = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_fracs.delete();
      outstanding_o <= 0;
    end else begin
      // result first: a beat taken on the same edge is never the one shown
      if (result_valid_i) begin
        if (expected_fracs.size() == 0) begin
          $error("result beat with nothing expected: num %0d den %0d status %0b",
                 result_i.res_num, result_i.res_den, result_i.status);
          fail_count_o++;
        end else begin
          want = expected_fracs.pop_front();
          checked_o++;
          if (want.status) err_status_o++;
          if (result_i.res_num !== want.res_num) begin
            $error("res_num: expected %0d, got %0d", want.res_num, result_i.res_num);
            fail_count_o++;
          end
          if (result_i.res_den !== want.res_den) begin
            $error("res_den: expected %0d, got %0d", want.res_den, result_i.res_den);
            fail_count_o++;
          end
          if (result_i.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, result_i.status);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) expected_fracs.push_back(reduced_fraction(operands_i));
      outstanding_o <= expected_fracs.size();
    end
  end

endmodule

[verif/tb_rational_fraction_alu_unit.sv]
// ----------------------------------------------------------------------------
// tb_rational_fraction_alu_unit
// Drives operand beats into the rational fraction ALU: a directed set of
// corner cases, then random fractions of mixed size with random gaps. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_rational_fraction_alu_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  localparam logic [31:0] MaxPos = 32'h7fff_ffff;
  localparam logic [31:0] MinNeg = 32'h8000_0000;
  localparam int          RandomBeats = 850;
  // leave plenty of room beyond the slowest item
  localparam int          DrainLimit  = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  in_t  operands = '0;
  logic busy;
  logic result_valid;
  out_t result;

  int outstanding;
  int chk_fail;
  int checked;
  int err_seen;
  int op_count[4];
  int sent;

  rational_fraction_alu_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operands_i     (operands),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  rfa_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .operands_i     (operands),
    .result_valid_i (result_valid),
    .result_i       (result),
    .outstanding_o  (outstanding),
    .fail_count_o   (chk_fail),
    .checked_o      (checked),
    .err_status_o   (err_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Present one beat and hold it until the block takes it. busy is read just
  // after the edge, i.e. the value the block saw at that edge. start is left
  // high on return so back-to-back beats need no second assignment.
  task automatic issue_beat(input logic [1:0] op, input logic [31:0] an, ad, bn, bd);
    start    <= 1'b1;
    operands <= {op, an, ad, bn, bd};   // packed order: opcode, a_num, a_den, b_num, b_den
    do @(posedge clk_i); while (busy);
    op_count[op]++;
    sent++;
  endtask

  // Mostly no gap or a short one, now and then a long stretch.
  task automatic idle_gap();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 50)      n = 0;
    else if (sel < 90) n = $urandom_range(1, 3);
    else               n = $urandom_range(20, 120);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected result has come back (or the limit runs out).
  task automatic drain_results(input int max_cycles);
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (outstanding != 0 && waited < max_cycles);
  endtask

  // Operand mix: small values keep Euclid short, the rest reach every bit
  // and the awkward extremes, zero included so zero denominators turn up.
  function automatic logic [31:0] pick_operand();
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      v = $urandom_range(0, 20);
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 70) begin
      v = $urandom_range(0, 65535);
      if ($urandom_range(0, 1)) v = -v;
    end else if (sel < 90) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 5))
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'hffff_ffff;
        3:       v = MaxPos;
        4:       v = MinNeg;
        default: v = 32'h8000_0001;
      endcase
    end
    return v;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed corner cases --------------------------------------------
    issue_beat(OP_ADD, 1, 2, 1, 3);                       idle_gap();
    issue_beat(OP_SUB, 1, 2, 1, 2);                       idle_gap(); // zero numerator
    issue_beat(OP_MUL, -3, 4, 8, -9);                     idle_gap(); // sign on a den
    issue_beat(OP_DIV, 3, 5, -7, 11);                     idle_gap();
    issue_beat(OP_DIV, 1, 2, 0, 5);                       idle_gap(); // divide by zero fraction
    issue_beat(OP_ADD, 5, 0, 1, 3);                       idle_gap(); // zero a_den
    issue_beat(OP_MUL, 5, 7, 1, 0);                       idle_gap(); // zero b_den
    issue_beat(OP_SUB, 0, 0, 0, 0);                       idle_gap();
    issue_beat(OP_ADD, MaxPos, 1, MaxPos, 1);             idle_gap();
    issue_beat(OP_SUB, 32'h8000_0001, 1, MaxPos, 1);      idle_gap();
    issue_beat(OP_ADD, MinNeg, MinNeg, MinNeg, MinNeg);   idle_gap(); // sum reaches 2^63
    issue_beat(OP_MUL, 1, MinNeg, 1, MinNeg);             idle_gap(); // den 2^62: too wide
    issue_beat(OP_DIV, MinNeg, 1, MinNeg, 1);             idle_gap();
    issue_beat(OP_MUL, MaxPos, 32'h7fff_fffe, 32'h7fff_fffe, MaxPos); idle_gap();
    issue_beat(OP_DIV, 0, MinNeg, 5, 3);                  idle_gap();
    issue_beat(OP_SUB, -1, -1, -1, -1);                   idle_gap();
    issue_beat(OP_ADD, MaxPos, 32'h7fff_fffe, 32'h7fff_fffd, MaxPos); idle_gap();
    issue_beat(OP_DIV, MinNeg, 3, MaxPos, MinNeg);        idle_gap();
    issue_beat(OP_MUL, -1, -1, -1, 1);
    // let the pipe run dry before the random part
    drain_results(DrainLimit);

    // --- random beats ------------------------------------------------------
    for (int i = 0; i < RandomBeats; i++) begin
      issue_beat(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                 pick_operand(), pick_operand());
      if (i == 300 || i == 600) drain_results(DrainLimit);
      else                      idle_gap();
    end

    // --- wind down ---------------------------------------------------------
    drain_results(DrainLimit);
    // keep the clock running so a stray result beat would still be caught
    repeat (100) @(posedge clk_i);
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);

    $display("Run covered %0d operand beats: %0d add, %0d sub, %0d mul, %0d div.",
             sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("Compared %0d results, %0d of them with error status.", checked, err_seen);
    if (chk_fail == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of all beats.
  initial begin
    #250_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rfa_pkg.sv
rtl/core/rfa_multiplier.sv
rtl/core/rfa_divider.sv
rtl/core/rational_fraction_alu_unit.sv
verif/rfa_checker.sv
verif/tb_rational_fraction_alu_unit.sv
